// ===== hdl/tpc_pkg.sv =====
package tpc_pkg;

    // fraction bits of the ratio t
    localparam int TFrac = 30;
    // distance width: three 64-bit floored terms plus plane term, with headroom
    localparam int DistW = 66;

    // register indexes
    typedef enum logic [2:0] {
        REG_PX = 3'd0,
        REG_PY = 3'd1,
        REG_PZ = 3'd2,
        REG_NX = 3'd3,
        REG_NY = 3'd4,
        REG_NZ = 3'd5
    } reg_idx_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MUL, ST_SUM, ST_EMIT0, ST_EMIT1
    } back_state_t;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vert_t;

    // classified triangle: three vertices, their distances, inside flags
    typedef struct packed {
        vert_t                    v0;
        vert_t                    v1;
        vert_t                    v2;
        logic signed [DistW-1:0]  d0;
        logic signed [DistW-1:0]  d1;
        logic signed [DistW-1:0]  d2;
        logic [2:0]               ins;
    } tri_t;

    // one output triangle
    typedef struct packed {
        vert_t o0;
        vert_t o1;
        vert_t o2;
        logic  last;
    } otri_t;

    function automatic coord_t sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

// ===== hdl/tpc_front.sv =====
// Front: two-stage distance pipeline and inside/outside classification.
module tpc_front #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpc_pkg::vert_t       pt,
    input  tpc_pkg::vert_t       nrm,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tpc_pkg::vert_t       iv0,
    input  tpc_pkg::vert_t       iv1,
    input  tpc_pkg::vert_t       iv2,
    output logic                 f_valid,
    input  logic                 f_ready,
    output tpc_pkg::tri_t        f_tri
);
    localparam int DW = tpc_pkg::DistW;

    // stage 1: products (12 multipliers, registered)
    logic                s1_valid_reg;
    logic signed [63:0]  p_reg [0:3][0:2];
    tpc_pkg::vert_t      s1v_reg [0:2];
    // stage 2: sums and distances
    logic                s2_valid_reg;
    tpc_pkg::tri_t       s2_reg;

    logic adv1, adv2;
    assign adv2 = !s2_valid_reg || f_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    logic signed [31:0] src [0:3][0:2];
    always_comb
    begin
        src[0][0] = iv0.x; src[0][1] = iv0.y; src[0][2] = iv0.z;
        src[1][0] = iv1.x; src[1][1] = iv1.y; src[1][2] = iv1.z;
        src[2][0] = iv2.x; src[2][1] = iv2.y; src[2][2] = iv2.z;
        src[3][0] = pt.x;  src[3][1] = pt.y;  src[3][2] = pt.z;
    end

    logic signed [31:0] nsel [0:2];
    assign nsel[0] = nrm.x;
    assign nsel[1] = nrm.y;
    assign nsel[2] = nrm.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv1)
            s1_valid_reg <= in_valid;
    end

    // products, floor-shifted (arithmetic shift is floor)
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 3; c++)
                    p_reg[r][c] <= (64'(nsel[c]) * 64'(src[r][c])) >>> COORD_FRAC_BITS;
            s1v_reg[0] <= iv0;
            s1v_reg[1] <= iv1;
            s1v_reg[2] <= iv2;
        end
    end

    logic signed [DW-1:0] dsum [0:3];
    logic signed [DW-1:0] vdist [0:2];
    always_comb
    begin
        for (int r = 0; r < 4; r++)
            dsum[r] = DW'(p_reg[r][0]) + DW'(p_reg[r][1]) + DW'(p_reg[r][2]);
        for (int r = 0; r < 3; r++)
            vdist[r] = dsum[r] - dsum[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_reg.v0  <= s1v_reg[0];
            s2_reg.v1  <= s1v_reg[1];
            s2_reg.v2  <= s1v_reg[2];
            s2_reg.d0  <= vdist[0];
            s2_reg.d1  <= vdist[1];
            s2_reg.d2  <= vdist[2];
            s2_reg.ins <= {!vdist[2][DW-1], !vdist[1][DW-1], !vdist[0][DW-1]};
        end
    end

    assign f_valid = s2_valid_reg;
    assign f_tri   = s2_reg;
endmodule

// ===== hdl/tpc_queue.sv =====
// Two-entry queue between front and back.
module tpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          w_valid,
    output logic          w_ready,
    input  tpc_pkg::tri_t w_data,
    output logic          r_valid,
    input  logic          r_ready,
    output tpc_pkg::tri_t r_data
);
    tpc_pkg::tri_t mem_reg [0:1];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr, rd;

    assign w_ready = cnt_reg != 2'd2;
    assign r_valid = cnt_reg != 2'd0;
    assign wr      = w_valid && w_ready;
    assign rd      = r_valid && r_ready;
    assign r_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= w_data;
    end
endmodule

// ===== hdl/tpc_div.sv =====
// Restoring divider for t = da/(da-db), 2 quotient bits per cycle.
module tpc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tpc_pkg::DistW-1:0]    num,
    input  logic signed [tpc_pkg::DistW-1:0]    den,
    output logic                                busy,
    output logic                                done,
    output logic [tpc_pkg::TFrac-1:0]           q
);
    localparam int DW = tpc_pkg::DistW;
    localparam int Steps = tpc_pkg::TFrac / 2;

    logic [DW:0]                  rem_reg, den_reg;
    logic [tpc_pkg::TFrac-1:0]    q_reg;
    logic [$clog2(Steps+1)-1:0]   cnt_reg;
    logic                         busy_reg, done_reg;

    logic [DW:0] r1, r2;
    logic        b1, b2;
    always_comb
    begin
        r1 = {rem_reg[DW-1:0], 1'b0};
        b1 = r1 >= den_reg;
        if (b1)
            r1 = r1 - den_reg;
        r2 = {r1[DW-1:0], 1'b0};
        b2 = r2 >= den_reg;
        if (b2)
            r2 = r2 - den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(Steps+1))'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= {1'b0, den};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= r2;
            q_reg   <= {q_reg[tpc_pkg::TFrac-3:0], b1, b2};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q    = q_reg;
endmodule

// ===== hdl/tpc_back.sv =====
// Back: sequencer that builds the output triangles, two shared dividers.
module tpc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  tpc_pkg::tri_t   q_tri,
    output logic            out_valid,
    input  logic            out_ready,
    output tpc_pkg::otri_t  out_tri
);
    localparam int DW = tpc_pkg::DistW;

    tpc_pkg::back_state_t state_reg, state_next;

    tpc_pkg::vert_t a0_reg, a1_reg, b_reg, c_reg;
    logic [1:0]     ni_reg;
    logic signed [DW-1:0] da0_reg, da1_reg, db0_reg, db1_reg;
    tpc_pkg::vert_t x0_reg, x1_reg;
    logic signed [63:0] m_reg [0:1][0:2];
    logic           started_reg;

    // output register
    logic           ov_reg;
    tpc_pkg::otri_t ot_reg;
    logic           ofree;
    assign ofree = !ov_reg || out_ready;

    // dividers: x0 uses (a0, b0), x1 uses (a0 or a1, b0 or b1)
    logic                       dstart;
    logic                       dbusy0, dbusy1, ddone0, ddone1;
    logic [tpc_pkg::TFrac-1:0]  t0, t1;
    logic [tpc_pkg::TFrac-1:0]  t0_reg, t1_reg;

    tpc_div u_div0 (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(da0_reg), .den(da0_reg - db0_reg),
        .busy(dbusy0), .done(ddone0), .q(t0)
    );
    tpc_div u_div1 (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(da1_reg), .den(da1_reg - db1_reg),
        .busy(dbusy1), .done(ddone1), .q(t1)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpc_pkg::ST_IDLE:
            begin
                if (q_valid && q_tri.ins != 3'b000)
                begin
                    if (q_tri.ins == 3'b111)
                        state_next = tpc_pkg::ST_EMIT1;
                    else
                        state_next = tpc_pkg::ST_DIV;
                end
            end
            tpc_pkg::ST_DIV:   if (ddone0 && ddone1) state_next = tpc_pkg::ST_MUL;
            tpc_pkg::ST_MUL:   state_next = tpc_pkg::ST_SUM;
            tpc_pkg::ST_SUM:   state_next = (ni_reg == 2'd2) ? tpc_pkg::ST_EMIT0
                                                             : tpc_pkg::ST_EMIT1;
            tpc_pkg::ST_EMIT0: if (ofree) state_next = tpc_pkg::ST_EMIT1;
            tpc_pkg::ST_EMIT1: if (ofree) state_next = tpc_pkg::ST_IDLE;
            default:  state_next = tpc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_ready = 1'b0;
        dstart  = 1'b0;
        case (state_reg)
            tpc_pkg::ST_IDLE: q_ready = 1'b1;
            tpc_pkg::ST_DIV:  dstart  = !dbusy0 && !dbusy1 && !ddone0 && !ddone1
                                        && !started_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tpc_pkg::ST_IDLE;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tpc_pkg::ST_DIV)
                started_reg <= 1'b1;
            else
                started_reg <= 1'b0;
            if ((state_reg == tpc_pkg::ST_EMIT0 || state_reg == tpc_pkg::ST_EMIT1) && ofree)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // sort vertices into inside and outside, keeping input order
    tpc_pkg::vert_t sa0, sa1, sb0, sb1;
    logic signed [DW-1:0] sda0, sda1, sdb0, sdb1;
    logic [1:0] sni;
    always_comb
    begin
        sa0 = q_tri.v0; sa1 = q_tri.v1; sb0 = q_tri.v2; sb1 = q_tri.v2;
        sda0 = q_tri.d0; sda1 = q_tri.d1; sdb0 = q_tri.d2; sdb1 = q_tri.d2;
        sni = 2'd3;
        case (q_tri.ins)
            3'b001: begin sni = 2'd1; sa0 = q_tri.v0; sda0 = q_tri.d0;
                    sb0 = q_tri.v1; sdb0 = q_tri.d1; sb1 = q_tri.v2; sdb1 = q_tri.d2; end
            3'b010: begin sni = 2'd1; sa0 = q_tri.v1; sda0 = q_tri.d1;
                    sb0 = q_tri.v0; sdb0 = q_tri.d0; sb1 = q_tri.v2; sdb1 = q_tri.d2; end
            3'b100: begin sni = 2'd1; sa0 = q_tri.v2; sda0 = q_tri.d2;
                    sb0 = q_tri.v0; sdb0 = q_tri.d0; sb1 = q_tri.v1; sdb1 = q_tri.d1; end
            3'b011: begin sni = 2'd2; sa0 = q_tri.v0; sda0 = q_tri.d0;
                    sa1 = q_tri.v1; sda1 = q_tri.d1; sb0 = q_tri.v2; sdb0 = q_tri.d2; end
            3'b101: begin sni = 2'd2; sa0 = q_tri.v0; sda0 = q_tri.d0;
                    sa1 = q_tri.v2; sda1 = q_tri.d2; sb0 = q_tri.v1; sdb0 = q_tri.d1; end
            3'b110: begin sni = 2'd2; sa0 = q_tri.v1; sda0 = q_tri.d1;
                    sa1 = q_tri.v2; sda1 = q_tri.d2; sb0 = q_tri.v0; sdb0 = q_tri.d0; end
            default: ;
        endcase
    end

    // second intersection operands depend on inside count
    tpc_pkg::vert_t xa1, xb1;
    assign xa1 = (ni_reg == 2'd2) ? a1_reg : a0_reg;
    assign xb1 = (ni_reg == 2'd2) ? b_reg  : c_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == tpc_pkg::ST_IDLE && q_valid)
        begin
            ni_reg  <= sni;
            if (q_tri.ins == 3'b111)
            begin
                a0_reg <= q_tri.v0; a1_reg <= q_tri.v1; b_reg <= q_tri.v2;
            end
            else
            begin
                a0_reg <= sa0; a1_reg <= sa1; b_reg <= sb0;
            end
            c_reg   <= sb1;
            da0_reg <= sda0;
            db0_reg <= sdb0;
            da1_reg <= (sni == 2'd2) ? sda1 : sda0;
            db1_reg <= (sni == 2'd2) ? sdb0 : sdb1;
        end
        if (ddone0)
            t0_reg <= t0;
        if (ddone1)
            t1_reg <= t1;
        // diff * t, one 33x31 signed product per coordinate
        if (state_reg == tpc_pkg::ST_MUL)
        begin
            m_reg[0][0] <= ((64'(b_reg.x) - 64'(a0_reg.x)) * $signed(64'(t0_reg)))
                           >>> tpc_pkg::TFrac;
            m_reg[0][1] <= ((64'(b_reg.y) - 64'(a0_reg.y)) * $signed(64'(t0_reg)))
                           >>> tpc_pkg::TFrac;
            m_reg[0][2] <= ((64'(b_reg.z) - 64'(a0_reg.z)) * $signed(64'(t0_reg)))
                           >>> tpc_pkg::TFrac;
            m_reg[1][0] <= ((64'(xb1.x) - 64'(xa1.x)) * $signed(64'(t1_reg)))
                           >>> tpc_pkg::TFrac;
            m_reg[1][1] <= ((64'(xb1.y) - 64'(xa1.y)) * $signed(64'(t1_reg)))
                           >>> tpc_pkg::TFrac;
            m_reg[1][2] <= ((64'(xb1.z) - 64'(xa1.z)) * $signed(64'(t1_reg)))
                           >>> tpc_pkg::TFrac;
        end
        if (state_reg == tpc_pkg::ST_SUM)
        begin
            x0_reg.x <= tpc_pkg::sat32(64'(a0_reg.x) + m_reg[0][0]);
            x0_reg.y <= tpc_pkg::sat32(64'(a0_reg.y) + m_reg[0][1]);
            x0_reg.z <= tpc_pkg::sat32(64'(a0_reg.z) + m_reg[0][2]);
            x1_reg.x <= tpc_pkg::sat32(64'(xa1.x) + m_reg[1][0]);
            x1_reg.y <= tpc_pkg::sat32(64'(xa1.y) + m_reg[1][1]);
            x1_reg.z <= tpc_pkg::sat32(64'(xa1.z) + m_reg[1][2]);
        end
        // result register
        if (ofree && state_reg == tpc_pkg::ST_EMIT0)
        begin
            ot_reg.o0   <= a0_reg;
            ot_reg.o1   <= a1_reg;
            ot_reg.o2   <= x0_reg;
            ot_reg.last <= 1'b0;
        end
        else if (ofree && state_reg == tpc_pkg::ST_EMIT1)
        begin
            ot_reg.last <= 1'b1;
            if (ni_reg == 2'd3)
            begin
                ot_reg.o0 <= a0_reg; ot_reg.o1 <= a1_reg; ot_reg.o2 <= b_reg;
            end
            else if (ni_reg == 2'd2)
            begin
                ot_reg.o0 <= a1_reg; ot_reg.o1 <= x0_reg; ot_reg.o2 <= x1_reg;
            end
            else
            begin
                ot_reg.o0 <= a0_reg; ot_reg.o1 <= x0_reg; ot_reg.o2 <= x1_reg;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_tri   = ot_reg;
endmodule

// ===== hdl/triangle_plane_clipper_top.sv =====
// Channel | Direction | Handshake                 | Word
// cfg     | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
// in      | in        | in_valid / in_ready       | v0_x .. v2_z
// out     | out       | out_valid / out_ready     | o0_x .. o2_z, last_of_run
// Front: distance pipeline, registered products then sums, one triangle per cycle when
// not stalled, into a 2-entry queue. Back: a fully inside triangle passes as one result,
// a fully outside one is dropped; a clipped one gives one result with one inside vertex,
// two with two, via divider start, radix-4 divide, hand-off, multiply, sum and emit steps.
// Reset (rst_n low, asynchronous) restores the plane registers and empties all stages.
// Either side may stall; the queue and output register hold words until taken.
module triangle_plane_clipper_top #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] v0_x, v0_y, v0_z,
    input  logic signed [31:0] v1_x, v1_y, v1_z,
    input  logic signed [31:0] v2_x, v2_y, v2_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] o0_x, o0_y, o0_z,
    output logic signed [31:0] o1_x, o1_y, o1_z,
    output logic signed [31:0] o2_x, o2_y, o2_z,
    output logic        last_of_run
);
    tpc_pkg::vert_t pt_reg, nrm_reg;

    assign cfg_ready = 1'b1;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg  <= '0;
            nrm_reg <= '{x: 32'sd0, y: 32'sd0, z: 32'sd65536};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpc_pkg::REG_PX: pt_reg.x  <= cfg_data;
                tpc_pkg::REG_PY: pt_reg.y  <= cfg_data;
                tpc_pkg::REG_PZ: pt_reg.z  <= cfg_data;
                tpc_pkg::REG_NX: nrm_reg.x <= cfg_data;
                tpc_pkg::REG_NY: nrm_reg.y <= cfg_data;
                tpc_pkg::REG_NZ: nrm_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    tpc_pkg::vert_t iv0, iv1, iv2;
    assign iv0 = '{x: v0_x, y: v0_y, z: v0_z};
    assign iv1 = '{x: v1_x, y: v1_y, z: v1_z};
    assign iv2 = '{x: v2_x, y: v2_y, z: v2_z};

    logic          f_valid, f_ready, q_valid, q_ready;
    tpc_pkg::tri_t f_tri, q_tri;
    tpc_pkg::otri_t ot;

    tpc_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .pt(pt_reg), .nrm(nrm_reg),
        .in_valid(in_valid), .in_ready(in_ready),
        .iv0(iv0), .iv1(iv1), .iv2(iv2),
        .f_valid(f_valid), .f_ready(f_ready), .f_tri(f_tri)
    );

    tpc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .w_valid(f_valid), .w_ready(f_ready), .w_data(f_tri),
        .r_valid(q_valid), .r_ready(q_ready), .r_data(q_tri)
    );

    tpc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_tri(q_tri),
        .out_valid(out_valid), .out_ready(out_ready), .out_tri(ot)
    );

    assign o0_x = ot.o0.x; assign o0_y = ot.o0.y; assign o0_z = ot.o0.z;
    assign o1_x = ot.o1.x; assign o1_y = ot.o1.y; assign o1_z = ot.o1.z;
    assign o2_x = ot.o2.x; assign o2_y = ot.o2.y; assign o2_z = ot.o2.z;
    assign last_of_run = ot.last;
endmodule
